// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the decimal number writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/lcdw_pkg.sv
// Types and constants shared by the decimal number writer.
package lcdw_pkg;

  localparam int unsigned LINE_W   = 2;
  localparam int unsigned COLUMN_W = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIGIT_W  = 4;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_RIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_LEFT  = 1'b1;

  localparam logic [BYTE_W-1:0] RESET_CURSOR_RIGHT = 8'h14;
  localparam logic [BYTE_W-1:0] RESET_CURSOR_LEFT  = 8'h10;

  localparam logic [BYTE_W-1:0] ADDR_BASE  = 8'h80;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  localparam int unsigned BLANK_FIX_ZEROS = 6;

  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    SEL_ADDR,
    SEL_RIGHT,
    SEL_LEFT,
    SEL_DIGIT,
    SEL_ZERO
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      conv;
    logic      shift;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic digit_zero;
  } dp_stat_t;

endpackage

// File: sv/lcdw_in_if.sv
// Request channel carrying line, column and value.
interface lcdw_in_if import lcdw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LINE_W-1:0]   line;
  logic [COLUMN_W-1:0] column;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output line, output column, output value, input ready);
  modport sink (input valid, input line, input column, input value, output ready);
endinterface

// File: sv/lcdw_out_if.sv
// Result channel carrying the LCD bytes of each request, one byte per transfer.
interface lcdw_out_if import lcdw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_command;
  logic [BYTE_W-1:0] lcd_byte;
  logic              last;

  modport source (output valid, output is_command, output lcd_byte, output last, input ready);
  modport sink (input valid, input is_command, input lcd_byte, input last, output ready);
endinterface

// File: sv/lcdw_cfg_if.sv
// Configuration write channel carrying a register index and data.
interface lcdw_cfg_if import lcdw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/lcdw_datapath.sv
// Datapath: digit extraction, digit shift line, command registers and output register.
module lcdw_datapath import lcdw_pkg::*; #(
  parameter int unsigned DIGITS = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [LINE_W-1:0]    in_line,
  input  logic [COLUMN_W-1:0]  in_column,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_command,
  output logic [BYTE_W-1:0]    out_lcd_byte,
  output logic                 out_last
);

  logic [BYTE_W-1:0]    right_cmd_r;
  logic [BYTE_W-1:0]    left_cmd_r;
  logic [BYTE_W-1:0]    addr_r;
  logic [BYTE_W-1:0]    addr_nxt;
  logic [VALUE_W-1:0]   val_r;
  logic [DIGIT_W-1:0]   digs_r [DIGITS];
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   rem_full;
  logic                 out_valid_r;
  logic                 out_is_command_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_last_r;
  logic [BYTE_W-1:0]    byte_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_cmd_r <= RESET_CURSOR_RIGHT;
      left_cmd_r  <= RESET_CURSOR_LEFT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CURSOR_RIGHT: right_cmd_r <= cfg_data;
        CFG_CURSOR_LEFT:  left_cmd_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The line selects a block of 64 addresses; everything wraps within one byte.
  assign addr_nxt = ADDR_BASE + {in_line - 2'd1, 6'd0} + ({2'd0, in_column} - 8'd1);

  assign prod     = {{VALUE_W{1'b0}}, val_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
  assign rem_full = val_r - (quot << 3) - (quot << 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= addr_nxt;
      val_r  <= in_value;
    end else if (cmd.conv) begin
      val_r <= quot;
    end
    if (cmd.conv) begin
      digs_r[0] <= rem_full[DIGIT_W-1:0];
      for (int k = 1; k < DIGITS; k++) begin
        digs_r[k] <= digs_r[k-1];
      end
    end else if (cmd.shift) begin
      for (int k = 0; k < DIGITS - 1; k++) begin
        digs_r[k] <= digs_r[k+1];
      end
      digs_r[DIGITS-1] <= '0;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_ADDR:  byte_nxt = addr_r;
      SEL_RIGHT: byte_nxt = right_cmd_r;
      SEL_LEFT:  byte_nxt = left_cmd_r;
      SEL_DIGIT: byte_nxt = ASCII_ZERO + {4'd0, digs_r[0]};
      SEL_ZERO:  byte_nxt = ASCII_ZERO;
      default:   byte_nxt = ASCII_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r       <= byte_nxt;
      out_is_command_r <= (cmd.sel != SEL_DIGIT) && (cmd.sel != SEL_ZERO);
      out_last_r       <= cmd.last;
    end
  end

  assign stat.slot_free  = !out_valid_r || out_ready;
  assign stat.digit_zero = (digs_r[0] == '0);

  assign out_valid      = out_valid_r;
  assign out_is_command = out_is_command_r;
  assign out_lcd_byte   = out_byte_r;
  assign out_last       = out_last_r;

endmodule

// File: sv/lcdw_ctrl.sv
// Controller: sequences digit extraction and the byte run of each request.
`include "assert_macros.svh"
module lcdw_ctrl import lcdw_pkg::*; #(
  parameter int unsigned DIGITS = 9
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int unsigned CNT_W = $clog2(DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);
  localparam logic [CNT_W-1:0] CNT_FIX  = CNT_W'(BLANK_FIX_ZEROS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_LEAD = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;
  localparam logic [2:0] S_FIX1 = 3'd5;
  localparam logic [2:0] S_FIX2 = 3'd6;
  localparam logic [2:0] S_FIX3 = 3'd7;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] skip_r;
  logic [CNT_W-1:0] skip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      skip_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    in_ready  = 1'b0;
    cmd       = '{load: 1'b0, conv: 1'b0, shift: 1'b0, emit: 1'b0,
                  sel: SEL_ADDR, last: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ADDR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ADDR: begin
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_ADDR;
          skip_nxt  = '0;
          state_nxt = S_LEAD;
        end
      end
      S_LEAD, S_DATA: begin
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (state_r == S_LEAD && cnt_r != CNT_LAST && stat.digit_zero) begin
            cmd.sel  = SEL_RIGHT;
            skip_nxt = skip_r + 1'b1;
          end else begin
            cmd.sel = SEL_DIGIT;
            if (cnt_r == CNT_LAST) begin
              cnt_nxt = '0;
              if (skip_r == CNT_FIX) begin
                state_nxt = S_FIX1;
              end else begin
                cmd.last  = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              state_nxt = S_DATA;
            end
          end
        end
      end
      S_FIX1: begin
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_LEFT;
          state_nxt = S_FIX2;
        end
      end
      S_FIX2: begin
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_LEFT;
          state_nxt = S_FIX3;
        end
      end
      S_FIX3: begin
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_ZERO;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, in_valid && in_ready, state_r == S_CONV)
  `ASSERT_IMPLIES(a_emit_needs_slot, clk, rst_n, cmd.emit, stat.slot_free)
  `ASSERT_IMPLIES(a_fix_after_six, clk, rst_n, state_r == S_FIX1, skip_r == CNT_FIX)
  `ASSERT_ALWAYS(a_cnt_in_range, clk, rst_n, cnt_r <= CNT_LAST)

endmodule

// File: sv/lcd_decimal_number_writer.sv
// Top level of the decimal number writer for character LCDs.
// Each request (line, column, value) yields a run of LCD bytes: the set-address
// command, one cursor-right command per leading zero digit, the remaining digits
// as ASCII, and a two-step cursor-left fix with an ASCII zero when exactly six
// zeros were skipped. A request is taken only while the controller is idle. The
// value is split into DIGITS decimal digits at one digit per cycle by a
// reciprocal multiplier, then the bytes leave at one per cycle through an output
// register while the output is not stalled. The configuration port always
// accepts writes.
module lcd_decimal_number_writer import lcdw_pkg::*; #(
  parameter int unsigned DIGITS = 9
) (
  input logic       clk,
  input logic       rst_n,
  lcdw_in_if.sink   in_bus,
  lcdw_out_if.source out_bus,
  lcdw_cfg_if.sink  cfg_bus
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lcdw_ctrl #(
    .DIGITS (DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcdw_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_line        (in_bus.line),
    .in_column      (in_bus.column),
    .in_value       (in_bus.value),
    .cfg_valid      (cfg_bus.valid),
    .cfg_ready      (cfg_bus.ready),
    .cfg_index      (cfg_bus.index),
    .cfg_data       (cfg_bus.data),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_is_command (out_bus.is_command),
    .out_lcd_byte   (out_bus.lcd_byte),
    .out_last       (out_bus.last)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the LCD decimal number writer.
`timescale 1ns / 1ps

module testbench;
  import lcdw_pkg::*;

  localparam int unsigned NUM_DIGITS    = 9;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned IDLE_PERCENT  = 10;

  typedef struct {
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic [VALUE_W-1:0]  value;
    bit                  wait_drain;
  } number_req_t;

  typedef struct {
    logic              is_command;
    logic [BYTE_W-1:0] lcd_byte;
    logic              last;
  } lcd_byte_t;

  logic clk;
  logic rst_n;

  lcdw_in_if  in_ch();
  lcdw_out_if out_ch();
  lcdw_cfg_if cfg_ch();

  lcd_decimal_number_writer #(.DIGITS(NUM_DIGITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  number_req_t pending_requests[$];
  lcd_byte_t   lcd_bytes_due[$];
  logic [BYTE_W-1:0] right_cmd;
  logic [BYTE_W-1:0] left_cmd;
  int unsigned requests_queued;
  int unsigned requests_taken;
  int unsigned mismatches;
  bit          steady_phase;
  bit          long_hold_req;
  bit          hold_started;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned ten_pow(input int unsigned k);
    longint unsigned p;
    p = 1;
    for (int unsigned i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  function automatic void predict_run(input logic [LINE_W-1:0] line,
                                      input logic [COLUMN_W-1:0] column,
                                      input logic [VALUE_W-1:0] value);
    logic [DIGIT_W-1:0] digits[NUM_DIGITS];
    longint unsigned v;
    int unsigned skipped;
    logic [BYTE_W-1:0] addr;
    lcd_byte_t run[$];
    v = value;
    skipped = 0;
    for (int unsigned i = 0; i < NUM_DIGITS; i++) begin
      digits[NUM_DIGITS-1-i] = DIGIT_W'(v % 10);
      v = v / 10;
    end
    addr = ADDR_BASE + (BYTE_W'(line) - 8'd1) * 8'h40 + (BYTE_W'(column) - 8'd1);
    run.push_back('{1'b1, addr, 1'b0});
    while (skipped < NUM_DIGITS - 1 && digits[skipped] == 0) begin
      run.push_back('{1'b1, right_cmd, 1'b0});
      skipped++;
    end
    for (int unsigned i = skipped; i < NUM_DIGITS; i++)
      run.push_back('{1'b0, ASCII_ZERO + BYTE_W'(digits[i]), 1'b0});
    if (skipped == BLANK_FIX_ZEROS) begin
      run.push_back('{1'b1, left_cmd, 1'b0});
      run.push_back('{1'b1, left_cmd, 1'b0});
      run.push_back('{1'b0, ASCII_ZERO, 1'b0});
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) lcd_bytes_due.push_back(run[i]);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_byte();
    lcd_byte_t want;
    if (lcd_bytes_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %02h", out_ch.lcd_byte));
      return;
    end
    want = lcd_bytes_due.pop_front();
    if (out_ch.is_command !== want.is_command)
      flag_mismatch($sformatf("is_command %b, expected %b", out_ch.is_command, want.is_command));
    if (out_ch.lcd_byte !== want.lcd_byte)
      flag_mismatch($sformatf("lcd_byte %02h, expected %02h", out_ch.lcd_byte, want.lcd_byte));
    if (out_ch.last !== want.last)
      flag_mismatch($sformatf("last %b, expected %b", out_ch.last, want.last));
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_run(in_ch.line, in_ch.column, in_ch.value);
        requests_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() != 0 &&
            (steady_phase || $urandom_range(99) >= IDLE_PERCENT) &&
            (!pending_requests[0].wait_drain || lcd_bytes_due.size() == 0)) begin
          in_ch.valid  <= 1'b1;
          in_ch.line   <= pending_requests[0].line;
          in_ch.column <= pending_requests[0].column;
          in_ch.value  <= pending_requests[0].value;
          void'(pending_requests.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_started = 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_byte();
      if (long_hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady_phase || $urandom_range(99) >= IDLE_PERCENT;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic queue_request(input int unsigned line, input int unsigned column,
                               input longint unsigned value, input bit wait_drain = 1'b0);
    number_req_t r;
    r.line       = LINE_W'(line);
    r.column     = COLUMN_W'(column);
    r.value      = VALUE_W'(value);
    r.wait_drain = wait_drain;
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  task automatic wait_idle();
    while (requests_taken != requests_queued || lcd_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cursor_cmds(input logic [BYTE_W-1:0] right, input logic [BYTE_W-1:0] left);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_CURSOR_RIGHT;
    cfg_ch.data  <= right;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    right_cmd = right;
    cfg_ch.index <= CFG_CURSOR_LEFT;
    cfg_ch.data  <= left;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    left_cmd = left;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic longint unsigned rand_value();
    longint unsigned lo;
    int unsigned k;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        k = $urandom_range(1, NUM_DIGITS);
        lo = ten_pow(k - 1);
        return lo + ($urandom % (9 * lo));
      end
      2: begin
        k = $urandom_range(0, 4);
        return k * ten_pow(NUM_DIGITS) + $urandom_range(100, 999);
      end
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned line;
    int unsigned column;
    for (int unsigned i = 0; i < count; i++) begin
      line   = ($urandom_range(99) < 90) ? $urandom_range(1, 2) : $urandom_range(0, 3);
      column = ($urandom_range(99) < 90) ? $urandom_range(1, 40) : $urandom_range(0, 63);
      queue_request(line, column, rand_value(), $urandom_range(14) == 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.line = '0;
    in_ch.column = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CURSOR_RIGHT;
    cfg_ch.data = '0;
    right_cmd = RESET_CURSOR_RIGHT;
    left_cmd = RESET_CURSOR_LEFT;
    requests_queued = 0;
    requests_taken = 0;
    mismatches = 0;
    steady_phase = 1'b0;
    long_hold_req = 1'b0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(1, 1, 0);
    queue_request(2, 40, 1);
    queue_request(1, 1, 999_999_999);
    queue_request(2, 1, 1_000_000_000);
    queue_request(1, 40, 32'hFFFF_FFFF);
    queue_request(1, 5, 100);
    queue_request(2, 7, 999);
    queue_request(1, 9, 12);
    queue_request(2, 3, 1000);
    queue_request(1, 2, 12_345_678);
    queue_request(2, 20, 100_000_000);
    queue_request(1, 11, 10);
    queue_request(0, 0, 4_000_000_555);
    queue_request(3, 63, 7, 1'b1);
    queue_request(0, 41, 2_147_483_648);
    queue_request(3, 0, 3_000_000_000);
    queue_request(2, 32, 123_456);
    queue_request(1, 16, 5_000_000_100);
    queue_request(2, 33, 55);
    queue_request(1, 17, 907);
    wait_idle();

    set_cursor_cmds(8'h00, 8'hFF);
    queue_request(1, 1, 0);
    queue_request(2, 2, 456);
    queue_random(33);
    wait_idle();

    set_cursor_cmds(8'hFF, 8'h00);
    queue_random(33);
    long_hold_req = 1'b1;
    wait_idle();

    set_cursor_cmds(8'(RESET_CURSOR_RIGHT ^ 8'h5A), 8'($urandom_range(0, 255)));
    steady_phase = 1'b1;
    queue_request(2, 40, 321);
    queue_random(33);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (lcd_bytes_due.size() != 0)
      flag_mismatch($sformatf("%0d bytes never arrived", lcd_bytes_due.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
